// ===== src/sssp_pkg.sv =====
// shared constants, types and tables of the spherical shell point sampler
// no dependencies; imported by sssp_cordic and spherical_shell_point_sampler
package sssp_pkg;

   localparam int RADIUS_WIDTH_DEF  = 24;
   localparam int UNIFORM_WIDTH_DEF = 16;

   // uniforms are left-aligned to this many fraction bits
   localparam int FRAC_BITS = 32;
   // radius mantissa and root widths
   localparam int MANT_BITS = 21;
   localparam int SQRT_BITS = 31;

   localparam int CORDIC_STEPS   = 30;
   localparam int TRIG_WIDTH     = 34;
   localparam int TRIG_OUT_WIDTH = 32;
   localparam int CORDIC_GAIN    = 652032874;
   localparam int ONE_Q30        = 1073741824;

   localparam int CSR_INDEX_WIDTH = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_INNER_RADIUS = 2'd0,
      CSR_OUTER_RADIUS = 2'd1
   } csr_index_type;

   // arctangent of 2^-i in units of 2^-32 turn
   function automatic logic signed [TRIG_WIDTH-1:0] turn_atan(input int idx);
      logic signed [TRIG_WIDTH-1:0] a;
      case (idx)
         0:  a = TRIG_WIDTH'(536870912);
         1:  a = TRIG_WIDTH'(316933406);
         2:  a = TRIG_WIDTH'(167458907);
         3:  a = TRIG_WIDTH'(85004756);
         4:  a = TRIG_WIDTH'(42667331);
         5:  a = TRIG_WIDTH'(21354465);
         6:  a = TRIG_WIDTH'(10679838);
         7:  a = TRIG_WIDTH'(5340245);
         8:  a = TRIG_WIDTH'(2670163);
         9:  a = TRIG_WIDTH'(1335087);
         10: a = TRIG_WIDTH'(667544);
         11: a = TRIG_WIDTH'(333772);
         12: a = TRIG_WIDTH'(166886);
         13: a = TRIG_WIDTH'(83443);
         14: a = TRIG_WIDTH'(41722);
         15: a = TRIG_WIDTH'(20861);
         16: a = TRIG_WIDTH'(10430);
         17: a = TRIG_WIDTH'(5215);
         18: a = TRIG_WIDTH'(2608);
         19: a = TRIG_WIDTH'(1304);
         20: a = TRIG_WIDTH'(652);
         21: a = TRIG_WIDTH'(326);
         22: a = TRIG_WIDTH'(163);
         23: a = TRIG_WIDTH'(81);
         24: a = TRIG_WIDTH'(41);
         25: a = TRIG_WIDTH'(20);
         26: a = TRIG_WIDTH'(10);
         27: a = TRIG_WIDTH'(5);
         28: a = TRIG_WIDTH'(3);
         29: a = TRIG_WIDTH'(1);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

// ===== src/sssp_cordic.sv =====
// pipelined cordic giving cosine and sine of a turn fraction, q.30
// depends on sssp_pkg; input, step and output registers move on advance
module sssp_cordic import sssp_pkg::*; (
   input  logic                             clock,
   input  logic                             advance,
   input  logic [FRAC_BITS-1:0]             angle,
   output logic signed [TRIG_OUT_WIDTH-1:0] cos_out,
   output logic signed [TRIG_OUT_WIDTH-1:0] sin_out
);

   localparam logic signed [TRIG_WIDTH-1:0] ONE = TRIG_WIDTH'(ONE_Q30);

   logic signed [TRIG_WIDTH-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [TRIG_WIDTH-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [TRIG_WIDTH-1:0] z_ff [0:CORDIC_STEPS];
   logic [1:0]                   quad_ff [0:CORDIC_STEPS];
   logic signed [TRIG_WIDTH-1:0] c0, s0;
   logic signed [TRIG_OUT_WIDTH-1:0] cos_in, sin_in;

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff[0]    <= TRIG_WIDTH'(CORDIC_GAIN);
         y_ff[0]    <= '0;
         z_ff[0]    <= TRIG_WIDTH'(angle[FRAC_BITS-3:0]);
         quad_ff[0] <= angle[FRAC_BITS-1 -: 2];
      end
   end

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      logic signed [TRIG_WIDTH-1:0] dx, dy;
      assign dx = x_ff[i] >>> i;
      assign dy = y_ff[i] >>> i;
      always_ff @(posedge clock) begin
         if (advance) begin
            if (!z_ff[i][TRIG_WIDTH-1]) begin
               x_ff[i+1] <= x_ff[i] - dy;
               y_ff[i+1] <= y_ff[i] + dx;
               z_ff[i+1] <= z_ff[i] - turn_atan(i);
            end else begin
               x_ff[i+1] <= x_ff[i] + dy;
               y_ff[i+1] <= y_ff[i] - dx;
               z_ff[i+1] <= z_ff[i] + turn_atan(i);
            end
            quad_ff[i+1] <= quad_ff[i];
         end
      end
   end

   // clamp to the unit range, then rotate by quadrant
   always_comb begin
      c0 = x_ff[CORDIC_STEPS];
      s0 = y_ff[CORDIC_STEPS];
      if (c0 > ONE) c0 = ONE;
      if (c0 < -ONE) c0 = -ONE;
      if (s0 > ONE) s0 = ONE;
      if (s0 < -ONE) s0 = -ONE;
      case (quad_ff[CORDIC_STEPS])
         2'd0: begin
            cos_in = TRIG_OUT_WIDTH'(c0);
            sin_in = TRIG_OUT_WIDTH'(s0);
         end
         2'd1: begin
            cos_in = TRIG_OUT_WIDTH'(-s0);
            sin_in = TRIG_OUT_WIDTH'(c0);
         end
         2'd2: begin
            cos_in = TRIG_OUT_WIDTH'(-c0);
            sin_in = TRIG_OUT_WIDTH'(-s0);
         end
         default: begin
            cos_in = TRIG_OUT_WIDTH'(s0);
            sin_in = TRIG_OUT_WIDTH'(-c0);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cos_out <= cos_in;
         sin_out <= sin_in;
      end
   end

endmodule

// ===== src/spherical_shell_point_sampler.sv =====
// top level of the spherical shell point sampler
// depends on sssp_pkg and sssp_cordic
//
// Draws one point uniformly inside the spherical shell between csr register 0
// (inner radius) and csr register 1 (outer radius), both unsigned Q8.16, from
// three Q0 uniforms per request. A request is taken every cycle while the pipeline
// is not stalled; the depth is set by the longest chain: capture, |cos|
// and 1 - cos^2 stages, the 31-step bit-by-bit square root of the polar sine,
// then the trig product, the radius product and the output register. The whole
// pipeline moves in lock step and holds when
// a finished result is stalled. Radius mantissas and cubes are recomputed from
// the csr registers in four free-running register stages, which settle
// before a request taken after the write reaches the stage that uses them.
// Coordinates are signed and truncated toward zero; csr writes are always ready.
module spherical_shell_point_sampler import sssp_pkg::*; #(
   parameter int RADIUS_WIDTH  = RADIUS_WIDTH_DEF,
   parameter int UNIFORM_WIDTH = UNIFORM_WIDTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   // request channel
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [UNIFORM_WIDTH-1:0]   req_uniform_radius,
   input  logic [UNIFORM_WIDTH-1:0]   req_uniform_azimuth,
   input  logic [UNIFORM_WIDTH-1:0]   req_uniform_polar,
   // result channel
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [RADIUS_WIDTH:0] rsp_pos_x,
   output logic signed [RADIUS_WIDTH:0] rsp_pos_y,
   output logic signed [RADIUS_WIDTH:0] rsp_pos_z,
   // csr write channel
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [RADIUS_WIDTH-1:0]    csr_wdata
);

   // stage map
   localparam int PROD_STAGE  = 5;   // u1 * |cube difference|
   localparam int T_STAGE     = 6;   // interpolated cube
   localparam int ROOT_STAGE  = T_STAGE + MANT_BITS;        // cube root done
   localparam int ACT_STAGE   = 2;   // |cos polar|
   localparam int TRIG_STAGE  = 34;  // sqrt and cordic aligned
   localparam int P_STAGE     = TRIG_STAGE + 1;             // st * |trig|
   localparam int M_STAGE     = P_STAGE + 1;                // radius products
   localparam int OUT_STAGE   = M_STAGE + 1;
   localparam int CUBE_WIDTH  = 3 * MANT_BITS;
   localparam int SQ_WIDTH    = 2 * MANT_BITS;
   localparam int PROD_WIDTH  = MANT_BITS + SQRT_BITS;
   localparam int V_WIDTH     = 2 * (SQRT_BITS - 1) + 1;

   logic adv;
   logic [OUT_STAGE:1] valid_ff;

   // ---------------- csr registers ----------------
   logic [RADIUS_WIDTH-1:0] inner_ff, outer_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff <= '0;
         outer_ff <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_INNER_RADIUS: inner_ff <= csr_wdata;
            CSR_OUTER_RADIUS: outer_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- radius derivation (free running) ----------------
   logic [31:0]          inner_w, outer_w, big_w;
   logic [5:0]           blen;
   logic signed [6:0]    sh_in;
   logic [MANT_BITS-1:0] ma_in, mb_in;
   logic [MANT_BITS-1:0] ma_ff, mb_ff, ma2_ff, mb2_ff;
   logic [5:0]           down_ff;
   logic [SQ_WIDTH-1:0]  sqa_ff, sqb_ff;
   logic [CUBE_WIDTH-1:0] cba_ff, cbb_ff, ca_ff, diff_ff;
   logic                 grow_ff;

   always_comb begin
      inner_w = 32'(inner_ff);
      outer_w = 32'(outer_ff);
      big_w   = (inner_w > outer_w) ? inner_w : outer_w;
      blen    = '0;
      for (int i = 0; i < 32; i++) begin
         if (big_w[i]) blen = 6'(i + 1);
      end
      sh_in = 7'(blen) - 7'(MANT_BITS);
      if (!sh_in[6]) begin
         ma_in = MANT_BITS'(inner_w >> sh_in[5:0]);
         mb_in = MANT_BITS'(outer_w >> sh_in[5:0]);
      end else begin
         ma_in = MANT_BITS'(inner_w << 6'(-sh_in));
         mb_in = MANT_BITS'(outer_w << 6'(-sh_in));
      end
   end

   always_ff @(posedge clock) begin
      // mantissas and final shift
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      down_ff <= 6'(7'sd30 - sh_in);
      // squares
      sqa_ff  <= SQ_WIDTH'(ma_ff) * SQ_WIDTH'(ma_ff);
      sqb_ff  <= SQ_WIDTH'(mb_ff) * SQ_WIDTH'(mb_ff);
      ma2_ff  <= ma_ff;
      mb2_ff  <= mb_ff;
      // cubes
      cba_ff  <= CUBE_WIDTH'(sqa_ff) * CUBE_WIDTH'(ma2_ff);
      cbb_ff  <= CUBE_WIDTH'(sqb_ff) * CUBE_WIDTH'(mb2_ff);
      // signed span of the cubes
      ca_ff   <= cba_ff;
      grow_ff <= cbb_ff >= cba_ff;
      diff_ff <= (cbb_ff >= cba_ff) ? (cbb_ff - cba_ff) : (cba_ff - cbb_ff);
   end

   // ---------------- handshake ----------------
   // the whole pipe advances unless a finished result is held
   assign adv       = !(valid_ff[OUT_STAGE] && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = valid_ff[OUT_STAGE];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[OUT_STAGE-1:1], req_valid};
      end
   end

   // ---------------- request capture ----------------
   logic [FRAC_BITS-1:0] u1_ff [1:PROD_STAGE-1];
   logic [FRAC_BITS-1:0] u2_ff, u3_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         u1_ff[1] <= FRAC_BITS'(req_uniform_radius) << (FRAC_BITS - UNIFORM_WIDTH);
         u2_ff    <= FRAC_BITS'(req_uniform_azimuth) << (FRAC_BITS - UNIFORM_WIDTH);
         u3_ff    <= FRAC_BITS'(req_uniform_polar) << (FRAC_BITS - UNIFORM_WIDTH);
         for (int k = 2; k < PROD_STAGE; k++) u1_ff[k] <= u1_ff[k-1];
      end
   end

   // ---------------- radius chain ----------------
   logic [CUBE_WIDTH-1:0] phi_ff, part;
   logic [63:0]           plo_ff;
   logic [CUBE_WIDTH-1:0] t_ff;

   assign part = phi_ff + CUBE_WIDTH'(plo_ff[63:32]);

   always_ff @(posedge clock) begin
      if (adv) begin
         // high and low halves of u1 * span
         phi_ff <= CUBE_WIDTH'(u1_ff[PROD_STAGE-1]) * CUBE_WIDTH'(diff_ff[CUBE_WIDTH-1:32]);
         plo_ff <= 64'(u1_ff[PROD_STAGE-1]) * 64'(diff_ff[31:0]);
         t_ff   <= grow_ff ? (ca_ff + part) : (ca_ff - part);
      end
   end

   // cube root, one bit per stage, tracking c^2 and c^3 incrementally
   logic [MANT_BITS-1:0]  cr_c_ff  [0:MANT_BITS-1];
   logic [SQ_WIDTH-1:0]   cr_c2_ff [0:MANT_BITS-1];
   logic [CUBE_WIDTH-1:0] cr_c3_ff [0:MANT_BITS-1];
   logic [CUBE_WIDTH-1:0] cr_t_ff  [0:MANT_BITS-1];

   for (genvar j = 0; j < MANT_BITS; j++) begin : g_cbrt
      localparam int B = MANT_BITS - 1 - j;
      logic [63:0] c_p, c2_p, c3_p, t_p, cand, cand2, cand3, c2s;
      if (j == 0) begin : g_first
         assign c_p  = '0;
         assign c2_p = '0;
         assign c3_p = '0;
         assign t_p  = 64'(t_ff);
      end else begin : g_next
         assign c_p  = 64'(cr_c_ff[j-1]);
         assign c2_p = 64'(cr_c2_ff[j-1]);
         assign c3_p = 64'(cr_c3_ff[j-1]);
         assign t_p  = 64'(cr_t_ff[j-1]);
      end
      assign c2s   = c2_p << B;
      assign cand  = c_p | (64'd1 << B);
      assign cand2 = c2_p + (c_p << (B + 1)) + (64'd1 << (2 * B));
      assign cand3 = c3_p + (c2s << 1) + c2s + (c_p << (2 * B + 1)) + (c_p << (2 * B))
                     + (64'd1 << (3 * B));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (cand3 <= t_p) begin
               cr_c_ff[j]  <= MANT_BITS'(cand);
               cr_c2_ff[j] <= SQ_WIDTH'(cand2);
               cr_c3_ff[j] <= CUBE_WIDTH'(cand3);
            end else begin
               cr_c_ff[j]  <= MANT_BITS'(c_p);
               cr_c2_ff[j] <= SQ_WIDTH'(c2_p);
               cr_c3_ff[j] <= CUBE_WIDTH'(c3_p);
            end
            cr_t_ff[j] <= CUBE_WIDTH'(t_p);
         end
      end
   end

   // radius mantissa waits for the trig path
   logic [MANT_BITS-1:0] c_dly_ff [ROOT_STAGE+1:P_STAGE];

   always_ff @(posedge clock) begin
      if (adv) begin
         c_dly_ff[ROOT_STAGE+1] <= cr_c_ff[MANT_BITS-1];
         for (int k = ROOT_STAGE + 2; k <= P_STAGE; k++) c_dly_ff[k] <= c_dly_ff[k-1];
      end
   end

   // ---------------- polar chain ----------------
   logic [SQRT_BITS-1:0] act_ff  [ACT_STAGE:P_STAGE];
   logic                 zneg_ff [ACT_STAGE:P_STAGE];
   logic [SQRT_BITS-1:0] half_u3, act_in;
   logic [V_WIDTH-1:0]   v_ff;

   // |2u - 1| in q.30 from the top bits of u3
   assign half_u3 = u3_ff[FRAC_BITS-1:1];
   assign act_in  = u3_ff[FRAC_BITS-1] ? (half_u3 - SQRT_BITS'(ONE_Q30))
                                       : (SQRT_BITS'(ONE_Q30) - half_u3);

   always_ff @(posedge clock) begin
      if (adv) begin
         act_ff[ACT_STAGE]  <= act_in;
         zneg_ff[ACT_STAGE] <= !u3_ff[FRAC_BITS-1];
         for (int k = ACT_STAGE + 1; k <= P_STAGE; k++) begin
            act_ff[k]  <= act_ff[k-1];
            zneg_ff[k] <= zneg_ff[k-1];
         end
         // 1 - cos^2 in q.60
         v_ff <= (V_WIDTH'(1) << (V_WIDTH - 1))
                 - V_WIDTH'(V_WIDTH'(act_ff[ACT_STAGE]) * V_WIDTH'(act_ff[ACT_STAGE]));
      end
   end

   // square root, one bit per stage
   logic [SQRT_BITS-1:0] sq_s_ff  [0:SQRT_BITS-1];
   logic [V_WIDTH-1:0]   sq_s2_ff [0:SQRT_BITS-1];
   logic [V_WIDTH-1:0]   sq_v_ff  [0:SQRT_BITS-1];

   for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
      localparam int B = SQRT_BITS - 1 - j;
      logic [63:0] s_p, s2_p, v_p, cand, cand2;
      if (j == 0) begin : g_first
         assign s_p  = '0;
         assign s2_p = '0;
         assign v_p  = 64'(v_ff);
      end else begin : g_next
         assign s_p  = 64'(sq_s_ff[j-1]);
         assign s2_p = 64'(sq_s2_ff[j-1]);
         assign v_p  = 64'(sq_v_ff[j-1]);
      end
      assign cand  = s_p | (64'd1 << B);
      assign cand2 = s2_p + (s_p << (B + 1)) + (64'd1 << (2 * B));
      always_ff @(posedge clock) begin
         if (adv) begin
            if (cand2 <= v_p) begin
               sq_s_ff[j]  <= SQRT_BITS'(cand);
               sq_s2_ff[j] <= V_WIDTH'(cand2);
            end else begin
               sq_s_ff[j]  <= SQRT_BITS'(s_p);
               sq_s2_ff[j] <= V_WIDTH'(s2_p);
            end
            sq_v_ff[j] <= V_WIDTH'(v_p);
         end
      end
   end

   // ---------------- azimuth chain ----------------
   logic signed [TRIG_OUT_WIDTH-1:0] cos_c, sin_c, cos_ff, sin_ff;

   sssp_cordic u_cordic (
      .clock   (clock),
      .advance (adv),
      .angle   (u2_ff),
      .cos_out (cos_c),
      .sin_out (sin_c)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         cos_ff <= cos_c;
         sin_ff <= sin_c;
      end
   end

   // ---------------- combine ----------------
   logic [SQRT_BITS-1:0]  acp, asp, px_ff, py_ff;
   logic                  xneg_p_ff, yneg_p_ff;
   logic [PROD_WIDTH-1:0] mx_ff, my_ff, mz_ff;
   logic                  xneg_m_ff, yneg_m_ff, zneg_m_ff;
   logic [PROD_WIDTH-1:0] ax, ay, az;
   logic [RADIUS_WIDTH-1:0] mag_x, mag_y, mag_z;

   assign acp = SQRT_BITS'(cos_ff[TRIG_OUT_WIDTH-1] ? -cos_ff : cos_ff);
   assign asp = SQRT_BITS'(sin_ff[TRIG_OUT_WIDTH-1] ? -sin_ff : sin_ff);

   always_ff @(posedge clock) begin
      if (adv) begin
         // polar sine times |trig|, q.30
         px_ff     <= SQRT_BITS'((62'(sq_s_ff[SQRT_BITS-1]) * 62'(acp)) >> 30);
         py_ff     <= SQRT_BITS'((62'(sq_s_ff[SQRT_BITS-1]) * 62'(asp)) >> 30);
         xneg_p_ff <= cos_ff[TRIG_OUT_WIDTH-1];
         yneg_p_ff <= sin_ff[TRIG_OUT_WIDTH-1];
         // scale by radius mantissa
         mx_ff     <= PROD_WIDTH'(c_dly_ff[P_STAGE]) * PROD_WIDTH'(px_ff);
         my_ff     <= PROD_WIDTH'(c_dly_ff[P_STAGE]) * PROD_WIDTH'(py_ff);
         mz_ff     <= PROD_WIDTH'(c_dly_ff[P_STAGE]) * PROD_WIDTH'(act_ff[P_STAGE]);
         xneg_m_ff <= xneg_p_ff;
         yneg_m_ff <= yneg_p_ff;
         zneg_m_ff <= zneg_ff[P_STAGE];
      end
   end

   // back to the radius scale, truncated toward zero
   assign ax = mx_ff >> down_ff;
   assign ay = my_ff >> down_ff;
   assign az = mz_ff >> down_ff;

   logic signed [RADIUS_WIDTH:0] x_in, y_in, z_in, x_ff, y_ff, z_ff;

   always_comb begin
      mag_x = RADIUS_WIDTH'(ax);
      mag_y = RADIUS_WIDTH'(ay);
      mag_z = RADIUS_WIDTH'(az);
      x_in = xneg_m_ff ? -$signed({1'b0, mag_x}) : $signed({1'b0, mag_x});
      y_in = yneg_m_ff ? -$signed({1'b0, mag_y}) : $signed({1'b0, mag_y});
      z_in = zneg_m_ff ? -$signed({1'b0, mag_z}) : $signed({1'b0, mag_z});
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign rsp_pos_x = x_ff;
   assign rsp_pos_y = y_ff;
   assign rsp_pos_z = z_ff;

endmodule
